>>> hw/rtl/rbmf_pkg.sv
package rbmf_pkg;

   // Window depth and sample format
   localparam int MAX_WINDOW = 256;
   localparam int SAMPLE_W   = 16;
   localparam int SLOT_W     = $clog2(MAX_WINDOW);
   localparam int CNT_W      = SLOT_W + 1;

   // Configuration register widths and reset values
   localparam int SIZE_W  = 9;
   localparam int RECIP_W = 17;
   localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(3);
   localparam logic [RECIP_W-1:0] RECIP_RESET = RECIP_W'(21845);

   // Arithmetic widths: exact window sum, product with the Q1.16 reciprocal
   localparam int SUM_W  = SAMPLE_W + SLOT_W;
   localparam int PROD_W = SUM_W + RECIP_W + 1;
   localparam int FRAC_W = 16;
   localparam int QUO_W  = PROD_W - FRAC_W;

   // APB-style register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic {
      REG_WINDOW_SIZE = 1'b0,
      REG_RECIPROCAL  = 1'b1
   } reg_index_type;

   // Zero acts as one, anything above the delay line depth saturates
   function automatic logic [CNT_W-1:0] active_size(input logic [SIZE_W-1:0] size);
      logic [CNT_W-1:0] n;
      begin
         if (size == '0) begin
            n = CNT_W'(1);
         end else if (int'(size) > MAX_WINDOW) begin
            n = CNT_W'(MAX_WINDOW);
         end else begin
            n = CNT_W'(size);
         end
         return n;
      end
   endfunction

endpackage

>>> hw/rtl/rbmf_req_if.sv
interface rbmf_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [rbmf_pkg::SAMPLE_W-1:0] sample;
   logic                                line_end;

   modport source (output valid, output sample, output line_end, input ready);
   modport sink   (input valid, input sample, input line_end, output ready);
endinterface

>>> hw/rtl/rbmf_rsp_if.sv
interface rbmf_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [rbmf_pkg::SAMPLE_W-1:0] mean;
   logic                                last;

   modport source (output valid, output mean, output last, input ready);
   modport sink   (input valid, input mean, input last, output ready);
endinterface

>>> hw/rtl/running_box_mean_filter.sv
// A mean passes the sum, multiply and round stage registers and the output register
// before it appears on rsp; a stall on rsp holds the whole pipeline in between.
// Throughput: one sample per cycle while rsp is not stalled; the delay line memory is
// read and written at the same slot in the accept cycle, so consecutive samples never
// wait on each other. Samples that only fill the window produce no transaction.
// Reset (synchronous, active high) empties the window and pipeline, restores
// window_size = 3 and reciprocal = 21845; the delay line itself is not cleared.
module running_box_mean_filter (
   input  logic                                clock,
   input  logic                                reset,
   rbmf_req_if.sink                            req_chan,
   rbmf_rsp_if.source                          rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rbmf_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [rbmf_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [rbmf_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   // Configuration registers
   logic [rbmf_pkg::SIZE_W-1:0]  size_ff;
   logic [rbmf_pkg::RECIP_W-1:0] recip_ff;

   // Window control state
   logic [rbmf_pkg::CNT_W-1:0]  fill_ff, fill_in;
   logic [rbmf_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic [rbmf_pkg::CNT_W-1:0]  act_size;
   logic [rbmf_pkg::CNT_W-1:0]  slot_inc;
   logic [rbmf_pkg::CNT_W-1:0]  fill_next;
   logic                        evict;

   // Delay line memory and its registered read
   logic signed [rbmf_pkg::SAMPLE_W-1:0] win_mem [rbmf_pkg::MAX_WINDOW];
   logic signed [rbmf_pkg::SAMPLE_W-1:0] old_ff;

   // Stage 1: sum update
   logic                                 s1_vld_ff, s1_evict_ff, s1_emit_ff, s1_last_ff;
   logic signed [rbmf_pkg::SAMPLE_W-1:0] s1_smp_ff;
   logic signed [rbmf_pkg::SUM_W-1:0]    sum_ff, sum_in;

   // Stage 2: multiply
   logic                                 s2_vld_ff, s2_last_ff;
   logic signed [rbmf_pkg::SUM_W-1:0]    s2_sum_ff;

   // Stage 3: round and saturate
   logic                                 s3_vld_ff, s3_last_ff;
   logic signed [rbmf_pkg::PROD_W-1:0]   s3_prod_ff;
   logic signed [rbmf_pkg::PROD_W-1:0]   rnd_prod;
   logic signed [rbmf_pkg::QUO_W-1:0]    quo;
   logic signed [rbmf_pkg::SAMPLE_W-1:0] sat_mean;

   // Output register
   logic                                 rsp_vld_ff, rsp_last_ff;
   logic signed [rbmf_pkg::SAMPLE_W-1:0] rsp_mean_ff;

   logic adv;
   logic accept;
   logic csr_wr;

   localparam logic signed [rbmf_pkg::QUO_W-1:0] MEAN_MAX =
      rbmf_pkg::QUO_W'((64'sd1 <<< (rbmf_pkg::SAMPLE_W - 1)) - 64'sd1);
   localparam logic signed [rbmf_pkg::QUO_W-1:0] MEAN_MIN =
      rbmf_pkg::QUO_W'(-(64'sd1 <<< (rbmf_pkg::SAMPLE_W - 1)));
   localparam logic signed [rbmf_pkg::PROD_W-1:0] HALF_LSB =
      rbmf_pkg::PROD_W'(64'sd1 <<< (rbmf_pkg::FRAC_W - 1));

   // Whole pipeline moves unless a result waits in the output register
   assign adv    = !rsp_vld_ff || rsp_chan.ready;
   assign accept = req_chan.valid && adv;
   assign req_chan.ready = adv;

   // Register port
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      case (rbmf_pkg::reg_index_type'(csr_paddr[2]))
         rbmf_pkg::REG_WINDOW_SIZE: csr_prdata = rbmf_pkg::CSR_DATA_W'(size_ff);
         rbmf_pkg::REG_RECIPROCAL:  csr_prdata = rbmf_pkg::CSR_DATA_W'(recip_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // Window bookkeeping for the accepted sample
   always_comb begin
      act_size  = rbmf_pkg::active_size(size_ff);
      evict     = fill_ff >= act_size;
      fill_next = evict ? fill_ff : fill_ff + rbmf_pkg::CNT_W'(1);
      slot_inc  = rbmf_pkg::CNT_W'(slot_ff) + rbmf_pkg::CNT_W'(1);
      if (req_chan.line_end) begin
         fill_in = '0;
         slot_in = '0;
      end else begin
         fill_in = fill_next;
         slot_in = (slot_inc >= act_size) ? '0 : slot_inc[rbmf_pkg::SLOT_W-1:0];
      end
   end

   // Read the oldest sample and overwrite it in the same cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         old_ff           <= win_mem[slot_ff];
         win_mem[slot_ff] <= req_chan.sample;
      end
   end

   // Add the new sample; once the window is full, drop the oldest
   always_comb begin
      sum_in = sum_ff + rbmf_pkg::SUM_W'(s1_smp_ff);
      if (s1_evict_ff) begin
         sum_in = sum_in - rbmf_pkg::SUM_W'(old_ff);
      end
   end

   // Round to nearest, ties up, then saturate
   always_comb begin
      rnd_prod = s3_prod_ff + HALF_LSB;
      quo      = rnd_prod[rbmf_pkg::PROD_W-1:rbmf_pkg::FRAC_W];
      if (quo > MEAN_MAX) begin
         sat_mean = MEAN_MAX[rbmf_pkg::SAMPLE_W-1:0];
      end else if (quo < MEAN_MIN) begin
         sat_mean = MEAN_MIN[rbmf_pkg::SAMPLE_W-1:0];
      end else begin
         sat_mean = quo[rbmf_pkg::SAMPLE_W-1:0];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff    <= rbmf_pkg::SIZE_RESET;
         recip_ff   <= rbmf_pkg::RECIP_RESET;
         fill_ff    <= '0;
         slot_ff    <= '0;
         sum_ff     <= '0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (accept) begin
            fill_ff <= fill_in;
            slot_ff <= slot_in;
         end
         if (adv) begin
            s1_vld_ff  <= accept;
            s2_vld_ff  <= s1_vld_ff && s1_emit_ff;
            s3_vld_ff  <= s2_vld_ff;
            rsp_vld_ff <= s3_vld_ff;
            if (s1_vld_ff) begin
               sum_ff <= s1_last_ff ? '0 : sum_in;
            end
         end
         // The user must write only while idle; the block does not enforce it. A new size empties the window
         if (csr_wr) begin
            case (rbmf_pkg::reg_index_type'(csr_paddr[2]))
               rbmf_pkg::REG_WINDOW_SIZE: begin
                  size_ff <= csr_pwdata[rbmf_pkg::SIZE_W-1:0];
                  fill_ff <= '0;
                  slot_ff <= '0;
                  sum_ff  <= '0;
               end
               rbmf_pkg::REG_RECIPROCAL: begin
                  recip_ff <= csr_pwdata[rbmf_pkg::RECIP_W-1:0];
               end
               default: begin
                  recip_ff <= recip_ff;
               end
            endcase
         end
      end
   end

   // Payload pipeline
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_smp_ff   <= req_chan.sample;
         s1_evict_ff <= evict;
         s1_emit_ff  <= fill_next >= act_size;
         s1_last_ff  <= req_chan.line_end;
         s2_sum_ff   <= sum_in;
         s2_last_ff  <= s1_last_ff;
         s3_prod_ff  <= rbmf_pkg::PROD_W'(s2_sum_ff) *
                        $signed({1'b0, recip_ff});
         s3_last_ff  <= s2_last_ff;
         rsp_mean_ff <= sat_mean;
         rsp_last_ff <= s3_last_ff;
      end
   end

   assign rsp_chan.valid = rsp_vld_ff;
   assign rsp_chan.mean  = rsp_mean_ff;
   assign rsp_chan.last  = rsp_last_ff;

   // Window never holds more samples than its size
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= act_size)
      else $error("fill count above window size");

   // Write slot stays inside the window
   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      rbmf_pkg::CNT_W'(slot_ff) < act_size)
      else $error("write slot outside window");

   // Line end empties the window
   a_line_clear: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.line_end |=> fill_ff == '0 && slot_ff == '0)
      else $error("window not cleared after line end");

   // Input stalls only behind a blocked result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> rsp_chan.valid && !rsp_chan.ready)
      else $error("input stalled without output back-pressure");

   // A filling sample yields no result further down
   a_no_fill_result: assert property (@(posedge clock) disable iff (reset)
      adv && s1_vld_ff && !s1_emit_ff |=> !s2_vld_ff)
      else $error("result from a window that was not full");

endmodule

>>> verif/tb_running_box_mean_filter.sv
module tb_running_box_mean_filter;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          DRAIN_PAD   = 8;
   localparam int          LONG_HOLD   = 100;
   localparam int          NUM_PHASES  = 11;
   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam longint      SMP_MAX     = (longint'(1) <<< (rbmf_pkg::SAMPLE_W - 1)) - 1;
   localparam longint      SMP_MIN     = -SMP_MAX - 1;

   typedef struct {
      logic signed [rbmf_pkg::SAMPLE_W-1:0] mean;
      logic                                 last;
   } mean_rec_type;

   typedef enum logic {
      ROW_ITEM = 1'b0,
      ROW_CSR  = 1'b1
   } row_kind_type;

   typedef struct {
      row_kind_type            kind;
      rbmf_pkg::reg_index_type reg_sel;
      int                      value;
      int                      sample;
      bit                      line_end;
      bit                      typed;
      int                      want_mean;
      bit                      want_last;
   } dir_row_type;

   // Directed rows: extremes, short line, size zero, saturation, rounding ties
   localparam int NUM_DIR_ROWS = 26;
   dir_row_type dir_rows [NUM_DIR_ROWS] = '{
      '{ROW_ITEM, rbmf_pkg::REG_WINDOW_SIZE, 0,  32767, 1'b0, 1'b0,      0, 1'b0},
      '{ROW_ITEM, rbmf_pkg::REG_WINDOW_SIZE, 0,  32767, 1'b0, 1'b0,      0, 1'b0},
      '{ROW_ITEM, rbmf_pkg::REG_WINDOW_SIZE, 0,  32767, 1'b1, 1'b1,  32767, 1'b1},
      '{ROW_ITEM, rbmf_pkg::REG_WINDOW_SIZE, 0, -32768, 1'b0, 1'b0,      0, 1'b0},
      '{ROW_ITEM, rbmf_pkg::REG_WINDOW_SIZE, 0, -32768, 1'b0, 1'b0,      0, 1'b0},
      '{ROW_ITEM, rbmf_pkg::REG_WINDOW_SIZE, 0, -32768, 1'b0, 1'b0,      0, 1'b0},
      '{ROW_ITEM, rbmf_pkg::REG_WINDOW_SIZE, 0,      0, 1'b0, 1'b0,      0, 1'b0},
      '{ROW_ITEM, rbmf_pkg::REG_WINDOW_SIZE, 0,      5, 1'b1, 1'b0,      0, 1'b0},
      '{ROW_ITEM, rbmf_pkg::REG_WINDOW_SIZE, 0,    100, 1'b0, 1'b0,      0, 1'b0},
      '{ROW_ITEM, rbmf_pkg::REG_WINDOW_SIZE, 0,    200, 1'b1, 1'b0,      0, 1'b0},
      '{ROW_CSR,  rbmf_pkg::REG_WINDOW_SIZE, 0,      0, 1'b0, 1'b0,      0, 1'b0},
      '{ROW_CSR,  rbmf_pkg::REG_RECIPROCAL,  65536,  0, 1'b0, 1'b0,      0, 1'b0},
      '{ROW_ITEM, rbmf_pkg::REG_WINDOW_SIZE, 0, -32768, 1'b0, 1'b1, -32768, 1'b0},
      '{ROW_ITEM, rbmf_pkg::REG_WINDOW_SIZE, 0,  32767, 1'b1, 1'b1,  32767, 1'b1},
      '{ROW_CSR,  rbmf_pkg::REG_WINDOW_SIZE, 2,      0, 1'b0, 1'b0,      0, 1'b0},
      '{ROW_ITEM, rbmf_pkg::REG_WINDOW_SIZE, 0,  32767, 1'b0, 1'b0,      0, 1'b0},
      '{ROW_ITEM, rbmf_pkg::REG_WINDOW_SIZE, 0,  32767, 1'b0, 1'b1,  32767, 1'b0},
      '{ROW_ITEM, rbmf_pkg::REG_WINDOW_SIZE, 0, -32768, 1'b0, 1'b0,      0, 1'b0},
      '{ROW_ITEM, rbmf_pkg::REG_WINDOW_SIZE, 0, -32768, 1'b1, 1'b1, -32768, 1'b1},
      '{ROW_CSR,  rbmf_pkg::REG_RECIPROCAL,  0,      0, 1'b0, 1'b0,      0, 1'b0},
      '{ROW_ITEM, rbmf_pkg::REG_WINDOW_SIZE, 0,   1234, 1'b0, 1'b0,      0, 1'b0},
      '{ROW_ITEM, rbmf_pkg::REG_WINDOW_SIZE, 0,     -1, 1'b1, 1'b1,      0, 1'b1},
      '{ROW_CSR,  rbmf_pkg::REG_RECIPROCAL,  32768,  0, 1'b0, 1'b0,      0, 1'b0},
      '{ROW_ITEM, rbmf_pkg::REG_WINDOW_SIZE, 0,      0, 1'b0, 1'b0,      0, 1'b0},
      '{ROW_ITEM, rbmf_pkg::REG_WINDOW_SIZE, 0,      1, 1'b0, 1'b0,      0, 1'b0},
      '{ROW_ITEM, rbmf_pkg::REG_WINDOW_SIZE, 0,     -2, 1'b1, 1'b0,      0, 1'b0}
   };

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [rbmf_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [rbmf_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [rbmf_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   rbmf_req_if req_chan ();
   rbmf_rsp_if rsp_chan ();

   running_box_mean_filter i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Window state of the mean predictor
   logic [rbmf_pkg::SIZE_W-1:0]          cfg_size;
   logic [rbmf_pkg::RECIP_W-1:0]         cfg_recip;
   logic signed [rbmf_pkg::SAMPLE_W-1:0] delay_line [rbmf_pkg::MAX_WINDOW];
   longint                               win_sum;
   int                                   fill_cnt;
   int                                   next_slot;

   mean_rec_type expected_means [$];
   int           error_count     = 0;
   int           holds_requested = 0;
   int unsigned  cycle_count     = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      error_count++;
      if (error_count <= 100) begin
         $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
      end
   endtask

   function automatic void clear_window();
      win_sum   = 0;
      fill_cnt  = 0;
      next_slot = 0;
   endfunction

   // Zero acts as one, anything above the delay line depth saturates
   function automatic int window_len(input logic [rbmf_pkg::SIZE_W-1:0] size);
      if (size == '0) return 1;
      if (int'(size) > rbmf_pkg::MAX_WINDOW) return rbmf_pkg::MAX_WINDOW;
      return int'(size);
   endfunction

   // Advance the window by one sample; return 1 when a mean comes out
   function automatic bit predict_mean(input logic signed [rbmf_pkg::SAMPLE_W-1:0] smp,
                                       input logic end_flag, output mean_rec_type res);
      int     n;
      longint scaled;
      bit     produced;
      n = window_len(cfg_size);
      produced = 1'b0;
      res = '{mean: '0, last: 1'b0};
      if (fill_cnt >= n) begin
         win_sum -= delay_line[next_slot];
      end else begin
         fill_cnt++;
      end
      delay_line[next_slot] = smp;
      win_sum += smp;
      next_slot = (next_slot + 1 >= n) ? 0 : next_slot + 1;
      if (fill_cnt >= n) begin
         // round half up, then clamp to the sample range
         scaled = (win_sum * longint'(cfg_recip) + 64'sd32768) >>> 16;
         if (scaled > SMP_MAX) scaled = SMP_MAX;
         if (scaled < SMP_MIN) scaled = SMP_MIN;
         res.mean = rbmf_pkg::SAMPLE_W'(scaled);
         res.last = end_flag;
         produced = 1'b1;
      end
      if (end_flag) clear_window();
      return produced;
   endfunction

   function automatic int idle_len();
      if ($urandom_range(0, 99) < 70) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   function automatic int sender_gap();
      if ($urandom_range(0, 99) < 55) return 0;
      return idle_len();
   endfunction

   function automatic logic signed [rbmf_pkg::SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(0, 9))
         0: return rbmf_pkg::SAMPLE_W'(SMP_MAX);
         1: return rbmf_pkg::SAMPLE_W'(SMP_MIN);
         default: return rbmf_pkg::SAMPLE_W'($urandom);
      endcase
   endfunction

   // Offer one sample, hold it until accepted, then record the mean it yields, if any
   task automatic send_item(input logic signed [rbmf_pkg::SAMPLE_W-1:0] smp,
                            input logic end_flag,
                            input int gap, input bit typed = 1'b0, input int want_mean = 0,
                            input bit want_last = 1'b0);
      mean_rec_type rec;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.sample   <= smp;
      req_chan.line_end <= end_flag;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      @(negedge clock);
      if (predict_mean(smp, end_flag, rec)) begin
         if (typed) rec = '{mean: rbmf_pkg::SAMPLE_W'(want_mean), last: want_last};
         expected_means.push_back(rec);
      end
   endtask

   // Stop sending and wait until every pending mean has come back
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (expected_means.size() != 0) @(posedge clock);
      repeat (DRAIN_PAD) @(negedge clock);
   endtask

   // One setup and access phase; psel stays high for a following transfer
   task automatic csr_cycle(input bit is_write, input rbmf_pkg::reg_index_type reg_sel,
                            input logic [rbmf_pkg::CSR_DATA_W-1:0] wdata,
                            output logic [rbmf_pkg::CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= rbmf_pkg::CSR_ADDR_W'(4 * int'(reg_sel));
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      rdata = csr_prdata;
      @(negedge clock);
   endtask

   // Write a register, read it back, and mirror it in the predictor
   task automatic csr_program(input rbmf_pkg::reg_index_type reg_sel, input int value);
      logic [rbmf_pkg::CSR_DATA_W-1:0] rdata;
      csr_cycle(1'b1, reg_sel, rbmf_pkg::CSR_DATA_W'(value), rdata);
      csr_cycle(1'b0, reg_sel, '0, rdata);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (rdata !== rbmf_pkg::CSR_DATA_W'(value)) begin
         report_mismatch("register readback", rdata, value);
      end
      if (reg_sel == rbmf_pkg::REG_WINDOW_SIZE) begin
         cfg_size = rbmf_pkg::SIZE_W'(value);
         clear_window();
      end else begin
         cfg_recip = rbmf_pkg::RECIP_W'(value);
      end
      @(negedge clock);
   endtask

   // Send one line; at split_at pause and change the reciprocal mid-window
   task automatic send_line(input int len, input bit gapless, input int split_at);
      for (int i = 0; i < len; i++) begin
         if (i == split_at) begin
            wait_drained();
            csr_program(rbmf_pkg::REG_RECIPROCAL, $urandom_range(0, 65536));
         end
         send_item(rand_sample(), i == len - 1, gapless ? 0 : sender_gap());
      end
   endtask

   // Result side: random stalls in alternating stretches, plus requested long holds
   initial begin : rsp_ready_driver
      int hold_left;
      int mode_left;
      int holds_served;
      bit stall_mode;
      hold_left      = 0;
      mode_left      = 0;
      holds_served   = 0;
      stall_mode     = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_served != holds_requested) begin
            hold_left = LONG_HOLD;
            holds_served++;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2) != 0;
            mode_left  = $urandom_range(20, 200);
         end
         mode_left--;
         if (hold_left == 0 && stall_mode && $urandom_range(0, 3) == 0) hold_left = idle_len();
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Compare each mean transaction with the oldest pending one
   always @(posedge clock) begin : mean_checker
      mean_rec_type want;
      if (reset === 1'b0 && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (expected_means.size() == 0) begin
            report_mismatch("mean with none pending", rsp_chan.mean, 0);
         end else begin
            want = expected_means.pop_front();
            if (rsp_chan.mean !== want.mean) report_mismatch("mean", rsp_chan.mean, want.mean);
            if (rsp_chan.last !== want.last) report_mismatch("last", rsp_chan.last, want.last);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin : stimulus
      logic [rbmf_pkg::CSR_DATA_W-1:0] rdata;
      int                              phase_size  [NUM_PHASES];
      int                              phase_recip [NUM_PHASES];
      int                              n;
      int                              budget;
      int                              sent;
      int                              len;
      int                              split;
      bit                              split_done;

      reset             = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.sample   = '0;
      req_chan.line_end = 1'b0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      cfg_size          = rbmf_pkg::SIZE_W'(3);
      cfg_recip         = rbmf_pkg::RECIP_W'(21845);
      clear_window();

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Check register values after reset
      csr_cycle(1'b0, rbmf_pkg::REG_WINDOW_SIZE, '0, rdata);
      if (rdata !== rbmf_pkg::CSR_DATA_W'(3)) begin
         report_mismatch("window_size after reset", rdata, 3);
      end
      csr_cycle(1'b0, rbmf_pkg::REG_RECIPROCAL, '0, rdata);
      if (rdata !== rbmf_pkg::CSR_DATA_W'(21845)) begin
         report_mismatch("reciprocal after reset", rdata, 21845);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);

      // Walk the directed table
      foreach (dir_rows[r]) begin
         if (dir_rows[r].kind == ROW_CSR) begin
            wait_drained();
            csr_program(dir_rows[r].reg_sel, dir_rows[r].value);
         end else begin
            send_item(rbmf_pkg::SAMPLE_W'(dir_rows[r].sample), dir_rows[r].line_end,
                      sender_gap(), dir_rows[r].typed, dir_rows[r].want_mean,
                      dir_rows[r].want_last);
         end
      end

      // Random phases: fixed settings with the extremes, then two random ones
      phase_size  = '{1, 2, 3, 4, 7, 16, 256, 511, 0, 0, 0};
      phase_recip = '{65536, 32768, 21845, 16384, 9362, 4096, 256, 256, 65536, 0, 0};
      phase_size[9]   = $urandom_range(1, 40);
      phase_recip[9]  = $urandom_range(0, 65536);
      phase_size[10]  = $urandom_range(0, 63);
      phase_recip[10] = $urandom_range(0, 65536);

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         csr_program(rbmf_pkg::REG_WINDOW_SIZE, phase_size[p]);
         csr_program(rbmf_pkg::REG_RECIPROCAL, phase_recip[p]);
         n          = window_len(rbmf_pkg::SIZE_W'(phase_size[p]));
         budget     = (n > 32) ? n + 40 : 100;
         sent       = 0;
         split_done = 1'b0;

         // Back-pressure: long receiver hold while samples keep coming
         if (p == 0) begin
            holds_requested++;
            send_line(60, 1'b1, -1);
            sent += 60;
         end

         while (sent < budget) begin
            if (n > 1 && $urandom_range(0, 99) < 15) begin
               len = $urandom_range(1, (n - 1 < 40) ? n - 1 : 40);
            end else begin
               len = n + $urandom_range(0, (3 * n < 60) ? 3 * n : 60);
            end
            // Trim the last line to the phase budget
            if (len > budget - sent) len = budget - sent;
            split = -1;
            if (!split_done && len >= 2 && (sent >= budget / 2 || n > 32)) begin
               split      = $urandom_range(1, len - 1);
               split_done = 1'b1;
            end
            send_line(len, $urandom_range(0, 3) == 0, split);
            sent += len;
         end

         // Leave a partial line for the next size write to drop
         repeat ($urandom_range(0, 3)) send_item(rand_sample(), 1'b0, sender_gap());
      end

      wait_drained();
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/rbmf_pkg.sv
hw/rtl/rbmf_req_if.sv
hw/rtl/rbmf_rsp_if.sv
hw/rtl/running_box_mean_filter.sv
verif/tb_running_box_mean_filter.sv
